// ===== sv/ausc_pkg.sv =====
// Shared types and constants for the HEVC access unit scanner.
`default_nettype none

package ausc_pkg;

    localparam int DEF_WINDOW_BITS = 31;

    localparam int LEN_W  = 25;   // 24-bit NAL length plus the 4 prefix bytes
    localparam int ACC_W  = 31;
    localparam int TYPE_W = 6;

    localparam logic [TYPE_W-1:0] UT_RASL_N    = 6'd8;
    localparam logic [TYPE_W-1:0] UT_RASL_R    = 6'd9;
    localparam logic [TYPE_W-1:0] UT_IDR_RADL  = 6'd19;
    localparam logic [TYPE_W-1:0] UT_IDR_NOLP  = 6'd20;
    localparam logic [TYPE_W-1:0] UT_CRA       = 6'd21;
    localparam logic [TYPE_W-1:0] UT_AUD       = 6'd35;
    localparam logic [TYPE_W-1:0] UT_EOB       = 6'd37;
    localparam logic [TYPE_W-1:0] UT_MAX       = 6'd40;

    typedef enum logic [1:0] {
        REASON_PARSE_FAIL = 2'd0,
        REASON_NEW_FRAME  = 2'd1,
        REASON_DELIMITER  = 2'd2,
        REASON_WINDOW_END = 2'd3
    } end_reason_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        start_of_window;
        logic [30:0] window_bytes;
    } in_item_t;

    typedef struct packed {
        logic [30:0] match_length;
        logic        keyframe;
        logic        confident;
        end_reason_t end_reason;
    } out_item_t;

    function automatic logic is_slice(input logic [TYPE_W-1:0] t);
        return (t == 6'd0) || (t == 6'd1) || (t == UT_RASL_N) || (t == UT_RASL_R) ||
               (t == UT_IDR_RADL) || (t == UT_CRA);
    endfunction

endpackage

`default_nettype wire

// ===== sv/ausc_ifs.sv =====
// Valid/ready channel interfaces for the scanner's byte input and result output.
`default_nettype none

interface ausc_byte_if import ausc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ausc_result_if import ausc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/hevc_access_unit_scanner_unit.sv =====
// Top level of the HEVC access unit scanner: input stage, step logic, result register.
//
//  Channel   Role    Item                                       Handshake
//  bytes     sink    byte_value, start_of_window, window_bytes  valid/ready
//  results   source  match_length, keyframe, confident,         valid/ready
//                    end_reason
//
// One byte item per clock while the result register is not stalled. A byte is held in
// the input register, is checked against the scanner state, and any result is loaded
// into the result register when the pipeline advances. The state update per byte is a
// single counter/compare step, so it sets the rate of one item per cycle while the
// result side does not stall.
// Reset clears the scan state; nothing is pending afterwards.
// A stalled result holds the pipeline; bytes keep flowing while the result register
// is empty or being drained in the same cycle.
`default_nettype none

module hevc_access_unit_scanner_unit import ausc_pkg::*;
#(
    parameter int WINDOW_BITS = DEF_WINDOW_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ausc_byte_if.sink     bytes,
    ausc_result_if.source results
);

    logic      advance;     // item in the input register may move on
    logic      item_valid;
    in_item_t  item;
    logic      core_fire;   // step logic consumes the held byte this cycle
    logic      res_valid;
    out_item_t res;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;

    // result register is free, or its item is taken this cycle
    assign advance   = !out_valid_reg || results.ready;
    assign core_fire = item_valid && advance;

    ausc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (bytes.valid),
        .in_ready   (bytes.ready),
        .in_data    (bytes.data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ausc_step #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (core_fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register: loads whenever the pipeline advances
    assign out_valid_next = advance ? (core_fire && res_valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_fire && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // a new result only ever follows a byte that went through the step logic
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        !core_fire |=> !$rose(out_valid_reg))
        else $error("result appeared without a processed byte");

    // an empty result register never back-pressures the byte input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> bytes.ready)
        else $error("input stalled with empty result register");

    // window exhaustion only follows an accepted NAL, so the length is nonzero
    a_window_end_len: assert property (@(posedge clk) disable iff (!rst_n)
        (core_fire && res_valid && res.end_reason == REASON_WINDOW_END)
            |-> res.match_length != '0)
        else $error("window exhausted with zero match length");

endmodule

`default_nettype wire

// ===== sv/ausc_in_stage.sv =====
// Input register stage: captures one byte item and holds it until the step logic takes it.
`default_nettype none

module ausc_in_stage import ausc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    input  wire logic     advance,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    // free slot, or the held item leaves this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

// ===== sv/ausc_step.sv =====
// Scanner state and the per-byte NAL check and access unit end logic.
`default_nettype none

module ausc_step import ausc_pkg::*;
#(
    parameter int WINDOW_BITS = DEF_WINDOW_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire in_item_t item,
    output logic          res_valid,
    output out_item_t     res
);

    localparam int WIN_IN_W = (WINDOW_BITS < 31) ? WINDOW_BITS : 31;
    localparam int CMP_W    = (WINDOW_BITS > LEN_W) ? WINDOW_BITS : LEN_W;

    typedef enum logic [2:0] {
        PH_LEN0     = 3'd0,
        PH_LEN1     = 3'd1,
        PH_LEN2     = 3'd2,
        PH_LEN3     = 3'd3,
        PH_HDR0     = 3'd4,
        PH_HDR1     = 3'd5,
        PH_PAYLOAD0 = 3'd6,
        PH_SKIP     = 3'd7
    } phase_t;

    logic                   scanning_reg,  scanning_next;
    phase_t                 phase_reg,     phase_next;
    logic [LEN_W-1:0]       nal_len_reg,   nal_len_next;
    logic [LEN_W-1:0]       left_reg,      left_next;
    logic [TYPE_W-1:0]      type_reg,      type_next;
    logic [5:0]             layer_reg,     layer_next;
    logic                   have_prev_reg, have_prev_next;
    logic [5:0]             prev_layer_reg, prev_layer_next;
    logic [ACC_W-1:0]       acc_reg,       acc_next;
    logic [WINDOW_BITS-1:0] win_reg,       win_next;
    logic                   kf_reg,        kf_next;
    logic                   any_reg,       any_next;

    // state as seen by this byte: a start item drops the running scan
    logic                   e_scanning;
    phase_t                 e_phase;
    logic [LEN_W-1:0]       e_nal_len;
    logic [LEN_W-1:0]       e_left;
    logic [TYPE_W-1:0]      e_type;
    logic [5:0]             e_layer;
    logic                   e_have_prev;
    logic [5:0]             e_prev_layer;
    logic [ACC_W-1:0]       e_acc;
    logic [WINDOW_BITS-1:0] e_win;
    logic                   e_kf;
    logic                   e_any;

    logic [7:0]             b;
    logic [23:0]            len24;
    logic [LEN_W-1:0]       len_total;
    logic [TYPE_W-1:0]      hdr_type;
    logic [5:0]             full_layer;
    logic                   do_accept;
    logic [LEN_W-1:0]       consumed;
    logic [ACC_W-1:0]       acc_sum;
    logic [WINDOW_BITS-1:0] win_sub;
    logic [LEN_W-1:0]       left_dec;

    always_comb
    begin
        if (item.start_of_window)
        begin
            e_scanning   = 1'b1;
            e_phase      = PH_LEN0;
            e_nal_len    = '0;
            e_left       = '0;
            e_type       = '0;
            e_layer      = '0;
            e_have_prev  = 1'b0;
            e_prev_layer = '0;
            e_acc        = '0;
            e_win        = WINDOW_BITS'(item.window_bytes[WIN_IN_W-1:0]);
            e_kf         = 1'b0;
            e_any        = 1'b0;
        end
        else
        begin
            e_scanning   = scanning_reg;
            e_phase      = phase_reg;
            e_nal_len    = nal_len_reg;
            e_left       = left_reg;
            e_type       = type_reg;
            e_layer      = layer_reg;
            e_have_prev  = have_prev_reg;
            e_prev_layer = prev_layer_reg;
            e_acc        = acc_reg;
            e_win        = win_reg;
            e_kf         = kf_reg;
            e_any        = any_reg;
        end
    end

    assign b          = item.byte_value;
    assign len24      = {e_nal_len[15:0], b};
    assign len_total  = {1'b0, len24} + LEN_W'(4);
    assign hdr_type   = b[6:1];
    assign full_layer = e_layer | {1'b0, b[7:3]};
    // length checks guarantee the NAL fits, so these never wrap
    assign acc_sum    = e_acc + ACC_W'(e_nal_len);
    assign win_sub    = e_win - WINDOW_BITS'(e_nal_len);
    assign left_dec   = (e_left != '0) ? (e_left - LEN_W'(1)) : e_left;

    always_comb
    begin
        scanning_next   = e_scanning;
        phase_next      = e_phase;
        nal_len_next    = e_nal_len;
        left_next       = e_left;
        type_next       = e_type;
        layer_next      = e_layer;
        have_prev_next  = e_have_prev;
        prev_layer_next = e_prev_layer;
        acc_next        = e_acc;
        win_next        = e_win;
        kf_next         = e_kf;
        any_next        = e_any;
        do_accept       = 1'b0;
        consumed        = LEN_W'(6);
        res_valid       = 1'b0;
        res.match_length = e_acc;
        res.keyframe     = e_kf;
        res.confident    = e_any;
        res.end_reason   = REASON_PARSE_FAIL;

        if (e_scanning)
        begin
            unique case (e_phase)
                PH_LEN0:
                begin
                    if (b != 8'd0 || e_win < WINDOW_BITS'(6))
                    begin
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        nal_len_next = '0;
                        phase_next   = PH_LEN1;
                    end
                end
                PH_LEN1:
                begin
                    nal_len_next = {1'b0, len24};
                    phase_next   = PH_LEN2;
                end
                PH_LEN2:
                begin
                    nal_len_next = {1'b0, len24};
                    phase_next   = PH_LEN3;
                end
                PH_LEN3:
                begin
                    nal_len_next = len_total;
                    if (len24 < 24'd2 || CMP_W'(len_total) > CMP_W'(e_win))
                    begin
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_HDR0:
                begin
                    type_next  = hdr_type;
                    layer_next = {b[0], 5'd0};
                    if (b[7] || hdr_type > UT_MAX ||
                        (is_slice(hdr_type) && e_nal_len < LEN_W'(7)))
                    begin
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    layer_next = full_layer;
                    if ((e_type == UT_EOB) != (b[2:0] == 3'd0))
                    begin
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        if (e_type == UT_IDR_RADL || e_type == UT_IDR_NOLP)
                        begin
                            kf_next = 1'b1;
                        end
                        if (is_slice(e_type))
                        begin
                            phase_next = PH_PAYLOAD0;
                        end
                        else if (e_type == UT_AUD && e_have_prev)
                        begin
                            res_valid      = 1'b1;
                            res.keyframe   = kf_next;
                            res.end_reason = REASON_DELIMITER;
                        end
                        else
                        begin
                            do_accept = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD0:
                begin
                    if (e_have_prev && (b[7] || e_layer != e_prev_layer))
                    begin
                        res_valid      = 1'b1;
                        res.end_reason = REASON_NEW_FRAME;
                    end
                    else
                    begin
                        do_accept = 1'b1;
                        consumed  = LEN_W'(7);
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_LEN0;
                    end
                end
            endcase

            if (do_accept)
            begin
                acc_next        = acc_sum;
                win_next        = win_sub;
                have_prev_next  = 1'b1;
                prev_layer_next = layer_next;
                if (win_sub == '0)
                begin
                    res_valid        = 1'b1;
                    res.match_length = acc_sum;
                    res.keyframe     = kf_next;
                    res.end_reason   = REASON_WINDOW_END;
                end
                else
                begin
                    any_next   = 1'b1;
                    left_next  = e_nal_len - consumed;
                    phase_next = (e_nal_len != consumed) ? PH_SKIP : PH_LEN0;
                end
            end

            if (res_valid)
            begin
                scanning_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg   <= 1'b0;
            phase_reg      <= PH_LEN0;
            nal_len_reg    <= '0;
            left_reg       <= '0;
            type_reg       <= '0;
            layer_reg      <= '0;
            have_prev_reg  <= 1'b0;
            prev_layer_reg <= '0;
            acc_reg        <= '0;
            win_reg        <= '0;
            kf_reg         <= 1'b0;
            any_reg        <= 1'b0;
        end
        else if (fire)
        begin
            scanning_reg   <= scanning_next;
            phase_reg      <= phase_next;
            nal_len_reg    <= nal_len_next;
            left_reg       <= left_next;
            type_reg       <= type_next;
            layer_reg      <= layer_next;
            have_prev_reg  <= have_prev_next;
            prev_layer_reg <= prev_layer_next;
            acc_reg        <= acc_next;
            win_reg        <= win_next;
            kf_reg         <= kf_next;
            any_reg        <= any_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the HEVC access unit scanner, with its own scan predictor.
`timescale 1ns / 1ps

module tb;
    import ausc_pkg::*;

    // Stop criterion: byte items accepted by the block, ignored ones included.
    localparam int ITEM_TARGET  = 1850;
    // Final stretch of the run is sent and drained with no idling on either side.
    localparam int CALM_FROM    = ITEM_TARGET * 85 / 100;
    // Pipeline is the input register plus the result register. Allow plenty.
    localparam int DRAIN_CYCLES = 20;
    // Worst quiet stretch in a correct run is an input gap next to a result stall plus
    // the pipeline, so reaching this limit means the block is stuck.
    localparam int QUIET_LIMIT  = 2000;

    // NAL unit types used by the stimulus that the package does not name.
    localparam logic [TYPE_W-1:0] UT_TRAIL_N    = 6'd0;
    localparam logic [TYPE_W-1:0] UT_TRAIL_R    = 6'd1;
    localparam logic [TYPE_W-1:0] UT_VPS        = 6'd32;
    localparam logic [TYPE_W-1:0] UT_SPS        = 6'd33;
    localparam logic [TYPE_W-1:0] UT_PPS        = 6'd34;
    localparam logic [TYPE_W-1:0] UT_FILLER     = 6'd38;
    localparam logic [TYPE_W-1:0] UT_SEI_PREFIX = 6'd39;
    localparam logic [TYPE_W-1:0] UT_UNSPEC_TOP = 6'd63;

    // Where the scanner is within the current NAL unit.
    typedef enum bit [2:0] {
        PH_LEN0,    // first length byte, must be zero
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,    // last length byte: range and window fit
        PH_HDR0,    // forbidden bit, type, layer msb
        PH_HDR1,    // layer lsbs, temporal id
        PH_SLICE,   // first payload byte of a slice: first-slice flag
        PH_SKIP     // rest of an accepted NAL
    } scan_phase_t;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the scan of each accepted byte item and keeps the
    // access unit results that must come out, oldest first.
    // ------------------------------------------------------------------
    class au_scoreboard;
        bit          scanning;
        scan_phase_t phase;
        bit [24:0]   nal_len;       // includes the 4 prefix bytes once checked
        bit [24:0]   skip_left;
        bit [5:0]    unit_kind;
        bit [5:0]    nal_layer;
        bit [5:0]    prev_layer;
        bit          have_prev;
        bit          saw_key;
        bit          accepted_any;
        bit [30:0]   au_len;
        bit [30:0]   win_left;
        out_item_t   pending_aus[$];
        int          errors;
        int          live_bytes;

        function new();
            clear();
            errors     = 0;
            live_bytes = 0;
        endfunction

        function void clear();
            scanning     = 1'b0;
            phase        = PH_LEN0;
            nal_len      = '0;
            skip_left    = '0;
            unit_kind    = '0;
            nal_layer    = '0;
            prev_layer   = '0;
            have_prev    = 1'b0;
            saw_key      = 1'b0;
            accepted_any = 1'b0;
            au_len       = '0;
            win_left     = '0;
        endfunction

        function bit is_vcl_slice(bit [5:0] t);
            case (t)
                UT_TRAIL_N, UT_TRAIL_R, UT_RASL_N, UT_RASL_R,
                UT_IDR_RADL, UT_CRA: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void close_au(end_reason_t why);
            out_item_t au;
            au.match_length = au_len;
            au.keyframe     = saw_key;
            au.confident    = accepted_any;
            au.end_reason   = why;
            pending_aus.push_back(au);
            scanning = 1'b0;
        endfunction

        // NAL joins the access unit; an exhausted window ends it on the spot.
        function void take_nal(int consumed);
            au_len     = au_len + nal_len;
            win_left   = win_left - nal_len;
            have_prev  = 1'b1;
            prev_layer = nal_layer;
            if (win_left == 0)
            begin
                close_au(REASON_WINDOW_END);
                return;
            end
            accepted_any = 1'b1;
            skip_left    = nal_len - 25'(consumed);
            phase        = (skip_left != 0) ? PH_SKIP : PH_LEN0;
        endfunction

        // Advance the scan by one accepted byte item.
        function void note_byte(in_item_t it);
            bit [7:0] b;
            bit [2:0] tid;
            b = it.byte_value;
            live_bytes++;
            if (it.start_of_window)
            begin
                clear();
                scanning = 1'b1;
                win_left = it.window_bytes;
            end
            if (!scanning)
                return;
            case (phase)
                PH_LEN0:
                begin
                    if (b != 0 || win_left < 6)
                        close_au(REASON_PARSE_FAIL);
                    else
                    begin
                        nal_len = '0;
                        phase   = PH_LEN1;
                    end
                end
                PH_LEN1:
                begin
                    nal_len = {1'b0, nal_len[15:0], b};
                    phase   = PH_LEN2;
                end
                PH_LEN2:
                begin
                    nal_len = {1'b0, nal_len[15:0], b};
                    phase   = PH_LEN3;
                end
                PH_LEN3:
                begin
                    nal_len = {1'b0, nal_len[15:0], b};
                    if (nal_len < 2)
                        close_au(REASON_PARSE_FAIL);
                    else
                    begin
                        nal_len = nal_len + 25'd4;
                        if (nal_len > win_left)
                            close_au(REASON_PARSE_FAIL);
                        else
                            phase = PH_HDR0;
                    end
                end
                PH_HDR0:
                begin
                    unit_kind = b[6:1];
                    if (b[7] || unit_kind > UT_MAX)
                        close_au(REASON_PARSE_FAIL);
                    else if (is_vcl_slice(unit_kind) && nal_len < 7)
                        close_au(REASON_PARSE_FAIL);
                    else
                    begin
                        nal_layer = {b[0], 5'b0};
                        phase     = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    nal_layer = nal_layer | {1'b0, b[7:3]};
                    tid       = b[2:0];
                    if ((unit_kind == UT_EOB) != (tid == 0))
                        close_au(REASON_PARSE_FAIL);
                    else
                    begin
                        if (unit_kind == UT_IDR_RADL || unit_kind == UT_IDR_NOLP)
                            saw_key = 1'b1;
                        if (is_vcl_slice(unit_kind))
                            phase = PH_SLICE;
                        else if (unit_kind == UT_AUD && have_prev)
                            close_au(REASON_DELIMITER);
                        else
                            take_nal(6);
                    end
                end
                PH_SLICE:
                begin
                    if (have_prev && (b[7] || nal_layer != prev_layer))
                        close_au(REASON_NEW_FRAME);
                    else
                        take_nal(7);
                end
                default:
                begin
                    if (skip_left > 0)
                        skip_left--;
                    if (skip_left == 0)
                        phase = PH_LEN0;
                end
            endcase
        endfunction

        task report(string what);
            $display("[%0t] access unit mismatch: %s", $time, what);
            errors++;
        endtask

        task check_au(out_item_t got);
            out_item_t want;
            if (pending_aus.size() == 0)
            begin
                report($sformatf("result with nothing pending (len %0d reason %0d)",
                                 got.match_length, got.end_reason));
                return;
            end
            want = pending_aus.pop_front();
            if (got.match_length !== want.match_length)
                report($sformatf("match_length %0d, want %0d",
                                 got.match_length, want.match_length));
            if (got.keyframe !== want.keyframe)
                report($sformatf("keyframe %b, want %b", got.keyframe, want.keyframe));
            if (got.confident !== want.confident)
                report($sformatf("confident %b, want %b", got.confident, want.confident));
            if (got.end_reason !== want.end_reason)
                report($sformatf("end_reason %0d, want %0d",
                                 got.end_reason, want.end_reason));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, channels, block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ausc_byte_if   bytes_ch ();
    ausc_result_if results_ch ();

    hevc_access_unit_scanner_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_ch),
        .results (results_ch)
    );

    au_scoreboard sb;
    bit           calm = 1'b0;    // no idling on either side once set
    int           idle_odds = 0;  // 0: no gaps, else one gap per about this many items
    int           quiet = 0;

    // Bytes of the window being built, and its total NAL length with prefixes.
    logic [7:0]   au_bytes[$];
    int           au_total;

    // ------------------------------------------------------------------
    // Monitor: both handshakes are sampled on the rising edge, before the
    // block's own updates for that edge land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (results_ch.valid && results_ch.ready)
                sb.check_au(results_ch.data);
            if (bytes_ch.valid && bytes_ch.ready)
                sb.note_byte(bytes_ch.data);
        end
    end

    // Watchdog: cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if ((bytes_ch.valid && bytes_ch.ready) || (results_ch.valid && results_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("hevc_access_unit_scanner_unit test failed");
            $finish;
        end
    end

    // Result side: ready drops in random bursts of random length.
    initial
    begin
        results_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                results_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hand one byte item over; returns at the edge where it is taken.
    task automatic send_byte(logic [7:0] b, logic sof, logic [30:0] win);
        in_item_t it;
        it.byte_value      = b;
        it.start_of_window = sof;
        it.window_bytes    = win;
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            bytes_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        bytes_ch.valid <= 1'b1;
        bytes_ch.data  <= it;
        do
            @(posedge clk);
        while (!bytes_ch.ready);
    endtask

    // Append one length-prefixed NAL. Long payloads are cut short: such a
    // window is either refused at the length check or dropped by the next start.
    function automatic void put_nal(int t, int layer, int tid, int len, bit forbid,
                                    bit first_slice);
        int body;
        au_bytes.push_back(8'h00);
        au_bytes.push_back(len[23:16]);
        au_bytes.push_back(len[15:8]);
        au_bytes.push_back(len[7:0]);
        au_bytes.push_back({forbid, t[5:0], layer[5]});
        au_bytes.push_back({layer[4:0], tid[2:0]});
        body = (len - 2 > 12) ? 12 : len - 2;
        for (int i = 0; i < body; i++)
            au_bytes.push_back((i == 0) ? {first_slice, 7'($urandom)} : 8'($urandom));
        au_total += len + 4;
    endfunction

    // Send the built bytes as one window; the first carries the start flag.
    task automatic emit_au(logic [30:0] win);
        for (int i = 0; i < au_bytes.size(); i++)
            send_byte(au_bytes[i], i == 0, (i == 0) ? win : 31'($urandom));
        au_bytes.delete();
        au_total = 0;
    endtask

    // Mostly plausible access units with random content; some broken ones.
    task automatic random_window();
        int n, t, layer, nl, tid, len, win;
        bit first_flag;
        n     = $urandom_range(1, 5);
        layer = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : 0;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    case ($urandom_range(0, 5))
                        0: t = UT_TRAIL_N;
                        1: t = UT_TRAIL_R;
                        2: t = UT_RASL_N;
                        3: t = UT_RASL_R;
                        4: t = UT_IDR_RADL;
                        default: t = UT_CRA;
                    endcase
                end
                4: t = UT_AUD;
                5: t = UT_EOB;
                6: t = UT_IDR_NOLP;
                7: t = $urandom_range(UT_VPS, UT_MAX);
                8: t = $urandom_range(0, UT_MAX);
                default: t = $urandom_range(0, UT_UNSPEC_TOP);
            endcase
            tid = (t == UT_EOB) ? 0 : $urandom_range(1, 7);
            if ($urandom_range(0, 15) == 0)
                tid = $urandom_range(0, 7);
            len = $urandom_range(3, 10);
            if ($urandom_range(0, 15) == 0)
                len = $urandom_range(0, 2);
            if ($urandom_range(0, 40) == 0)
                len = $urandom_range(0, 24'hFF_FFFF);
            nl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : layer;
            first_flag = (k == 0) || ($urandom_range(0, 3) == 0);
            put_nal(t, nl, tid, len, $urandom_range(0, 31) == 0, first_flag);
        end
        case ($urandom_range(0, 7))
            0, 1, 2: win = au_total;
            3, 4:    win = au_total + $urandom_range(0, 12);
            5:       win = (au_total > 8) ? au_total - $urandom_range(1, 8) : au_total;
            6:       win = $urandom_range(0, 20);
            default: win = $urandom_range(0, 32'h7FFF_FFFF);
        endcase
        // occasional corrupted byte anywhere in the window
        if ($urandom_range(0, 7) == 0)
            au_bytes[$urandom_range(0, au_bytes.size() - 1)] = 8'($urandom);
        // trailing bytes: either the start of another NAL or plain noise
        repeat ($urandom_range(0, 3))
            au_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
        emit_au(win[30:0]);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        au_total = 0;
        rst_n          <= 1'b0;
        bytes_ch.valid <= 1'b0;
        bytes_ch.data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // bytes before any window are ignored
        send_byte(8'h00, 1'b0, 31'h7FFF_FFFF);
        send_byte(8'hFF, 1'b0, 31'h0);

        // nonzero top length byte
        au_bytes.push_back(8'hFF);
        emit_au(31'd100);
        // window too small for any NAL, and empty window
        put_nal(UT_VPS, 0, 1, 4, 1'b0, 1'b0);
        emit_au(31'd5);
        put_nal(UT_VPS, 0, 1, 4, 1'b0, 1'b0);
        emit_au(31'd0);
        // length below two
        put_nal(UT_VPS, 0, 1, 1, 1'b0, 1'b0);
        emit_au(31'd100);
        // largest NAL length filling the window exactly: ends on its header
        put_nal(UT_SPS, 0, 1, 24'hFF_FFFF, 1'b0, 1'b0);
        emit_au(31'h100_0003);
        // NAL longer than the window
        put_nal(UT_PPS, 0, 1, 10, 1'b0, 1'b0);
        emit_au(31'd13);
        // forbidden bit, type just above the top, highest type
        put_nal(UT_VPS, 0, 1, 4, 1'b1, 1'b0);
        emit_au(31'd100);
        put_nal(UT_MAX + 1, 0, 1, 4, 1'b0, 1'b0);
        emit_au(31'd100);
        put_nal(UT_UNSPEC_TOP, 0, 1, 4, 1'b0, 1'b0);
        emit_au(31'd100);
        // slice too short for its first payload byte
        put_nal(UT_IDR_RADL, 0, 1, 2, 1'b0, 1'b0);
        emit_au(31'd100);
        // end of bitstream wants temporal id zero, everything else nonzero
        put_nal(UT_EOB, 0, 0, 2, 1'b0, 1'b0);
        put_nal(UT_MAX, 0, 7, 2, 1'b0, 1'b0);
        put_nal(UT_EOB, 0, 3, 2, 1'b0, 1'b0);
        emit_au(31'd100);
        put_nal(UT_SEI_PREFIX, 0, 0, 3, 1'b0, 1'b0);
        emit_au(31'd100);
        // leading delimiter accepted; second one ends the unit
        put_nal(UT_AUD, 0, 1, 3, 1'b0, 1'b0);
        put_nal(UT_IDR_RADL, 0, 1, 5, 1'b0, 1'b0);
        put_nal(UT_CRA, 0, 2, 4, 1'b0, 1'b0);
        put_nal(UT_AUD, 0, 1, 3, 1'b0, 1'b0);
        emit_au(31'd200);
        // non-slice keyframe type, then a slice flagged as first of a new frame
        put_nal(UT_IDR_NOLP, 0, 7, 2, 1'b0, 1'b0);
        put_nal(UT_TRAIL_R, 0, 1, 4, 1'b0, 1'b1);
        emit_au(31'd200);
        // layer change between slices, top layer number
        put_nal(UT_TRAIL_N, 0, 1, 3, 1'b0, 1'b1);
        put_nal(UT_RASL_R, 63, 1, 3, 1'b0, 1'b0);
        emit_au(31'd200);
        // largest window and length: accepted, then dropped by the next start
        put_nal(UT_FILLER, 0, 1, 24'hFF_FFFF, 1'b0, 1'b0);
        emit_au(31'h7FFF_FFFF);
        // two NALs filling the window exactly; idle bytes after the result
        put_nal(UT_RASL_N, 0, 1, 3, 1'b0, 1'b0);
        put_nal(UT_FILLER, 0, 1, 2, 1'b0, 1'b0);
        au_bytes.push_back(8'h00);
        au_bytes.push_back(8'h5A);
        emit_au(31'd13);
        // window left below a full prefix after one NAL
        put_nal(UT_TRAIL_R, 0, 1, 3, 1'b0, 1'b0);
        au_bytes.push_back(8'h00);
        emit_au(31'd10);

        // --- random part ---
        while (sb.live_bytes < ITEM_TARGET)
        begin
            calm = (sb.live_bytes >= CALM_FROM);
            case ($urandom_range(0, 3))
                0: idle_odds = 0;
                1: idle_odds = 2;
                2: idle_odds = 6;
                default: idle_odds = 20;
            endcase
            random_window();
        end
        bytes_ch.valid <= 1'b0;

        // drain, then give stray results a chance to show up
        while (sb.pending_aus.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("hevc_access_unit_scanner_unit test passed");
        else
            $display("hevc_access_unit_scanner_unit test failed");
        $finish;
    end

endmodule

// ===== hevc_access_unit_scanner_unit.f =====
sv/ausc_pkg.sv
sv/ausc_ifs.sv
sv/ausc_in_stage.sv
sv/ausc_step.sv
sv/hevc_access_unit_scanner_unit.sv
tb/tb.sv
